// ----- rtl/ntpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// ntpsc_pkg
// Shared types and constants of the NTP seconds to civil time converter.
// ----------------------------------------------------------------------------
package ntpsc_pkg;

	localparam logic [31:0] NTP_UNIX_DIFF = 32'd2208988800;

	localparam int unsigned SEC_PER_MIN   = 60;
	localparam int unsigned MIN_PER_HOUR  = 60;
	localparam int unsigned HOUR_PER_DAY  = 24;

	// floor(2^k / d) with k the width of the dividend
	localparam logic [26:0] RCP_60_W32    = 27'd71582788;
	localparam logic [21:0] RCP_60_W27    = 22'd2236962;
	localparam logic [16:0] RCP_24_W21    = 17'd87381;
	localparam logic [7:0]  RCP_1460_W18  = 8'd179;
	localparam logic [9:0]  RCP_365_W18   = 10'd718;

	localparam logic [19:0] EPOCH_DAYS    = 20'd719468;
	localparam int unsigned DAYS_PER_ERA  = 146097;
	localparam int unsigned DAYS_PER_4Y   = 1460;
	localparam int unsigned DAYS_PER_CENT = 36524;
	localparam int unsigned ERA_LAST_DAY  = 146096;
	localparam int unsigned DAYS_PER_YEAR = 365;
	localparam int unsigned YEARS_PER_ERA = 400;
	localparam int unsigned MP_DAYS       = 153;
	localparam int unsigned MP_MARCH_OFS  = 3;
	localparam int unsigned MP_JAN_OFS    = 9;
	localparam int unsigned MP_JAN       = 10;

	localparam logic REG_UTC_OFFSET = 1'b0;

	typedef struct packed {
		logic       ok;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} hms_t;

	typedef struct packed {
		hms_t        hms;
		logic [19:0] z;
	} tod_t;

	typedef struct packed {
		logic        ok;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} civ_t;

endpackage

// ----- rtl/ntp_seconds_to_civil_time_top.sv -----
// ----------------------------------------------------------------------------
// ntp_seconds_to_civil_time_top
// NTP transmit seconds to local civil date and time, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one timestamp per clock unless a low res_ready stalls
// the pipeline: 7 stages shift the epoch, add the offset and split off
// seconds, minutes and hours, 8 stages turn the day count into a date, and
// one output register zeroes results for timestamps at or before the start
// of 1970. The divisions by 60, 24, 1460 and 365 are reciprocal multiplies
// followed by a one-step correction in the next stage; the other quotients
// come from compares against constant multiples. ntp_ready drops only when
// every stage is full and res_ready is low. Write utc_offset only while no
// item is in flight.
module ntp_seconds_to_civil_time_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        ntp_valid,
	output logic        ntp_ready,
	input  logic [31:0] ntp_seconds,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        time_valid,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);
	import ntpsc_pkg::*;

	logic [16:0] utc_offset;
	logic        tod_valid, tod_ready;
	tod_t        tod_data;
	logic        date_valid, date_ready;
	civ_t        date_data;
	logic        res_valid_q;
	civ_t        res_q;

	ntpsc_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.utc_offset (utc_offset)
	);

	ntpsc_tod u_tod (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (ntp_valid),
		.in_ready    (ntp_ready),
		.ntp_seconds (ntp_seconds),
		.utc_offset  (utc_offset),
		.out_valid   (tod_valid),
		.out_ready   (tod_ready),
		.out_data    (tod_data)
	);

	ntpsc_date u_date (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tod_valid),
		.in_ready  (tod_ready),
		.in_data   (tod_data),
		.out_valid (date_valid),
		.out_ready (date_ready),
		.out_data  (date_data)
	);

	assign date_ready = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (date_ready) begin
			res_valid_q <= date_valid;
		end
	end

	// drop all fields of a timestamp at or before the start of 1970
	always_ff @(posedge clk) begin
		if (date_ready) begin
			res_q <= date_data.ok ? date_data : '0;
		end
	end

	assign res_valid    = res_valid_q;
	assign time_valid   = res_q.ok;
	assign year         = res_q.year;
	assign month        = res_q.month;
	assign day_of_month = res_q.day;
	assign hour         = res_q.hour;
	assign minute       = res_q.minute;
	assign second       = res_q.second;

endmodule

// ----- rtl/ntpsc_cfg.sv -----
// ----------------------------------------------------------------------------
// ntpsc_cfg
// APB register file holding the signed local time offset.
// ----------------------------------------------------------------------------
module ntpsc_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [16:0] utc_offset
);
	import ntpsc_pkg::*;

	logic [16:0] offset_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_UTC_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (wr_en) begin
			offset_q <= pwdata[16:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_UTC_OFFSET) begin
			prdata = {15'd0, offset_q};
		end
	end

	assign utc_offset = offset_q;

endmodule

// ----- rtl/ntpsc_tod.sv -----
// ----------------------------------------------------------------------------
// ntpsc_tod
// Epoch shift, offset add and split into seconds, minutes, hours and days.
// ----------------------------------------------------------------------------
module ntpsc_tod (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       ntp_seconds,
	input  logic [16:0]       utc_offset,
	output logic              out_valid,
	input  logic              out_ready,
	output ntpsc_pkg::tod_t   out_data
);
	import ntpsc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;
	logic ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6, ok_s7;

	logic [31:0] t_s1, t_s2;
	logic [26:0] q_s2;
	logic [5:0]  sec_s3, sec_s4, sec_s5, sec_s6, sec_s7;
	logic [26:0] t1_s3, t1_s4;
	logic [20:0] q_s4;
	logic [5:0]  min_s5, min_s6, min_s7;
	logic [20:0] t2_s5, t2_s6;
	logic [15:0] q_s6;
	logic [4:0]  hr_s7;
	logic [19:0] z_s7;

	logic [58:0] p1;
	logic [31:0] diff1;
	logic [6:0]  r1;
	logic        c1;
	logic [48:0] p2;
	logic [26:0] diff2;
	logic [6:0]  r2;
	logic        c2;
	logic [37:0] p3;
	logic [20:0] diff3;
	logic [5:0]  r3;
	logic        c3;
	logic [15:0] t3;

	assign rdy_s7   = !v_s7 || out_ready;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		p1    = 59'(t_s1) * 59'(RCP_60_W32);
		diff1 = t_s2 - 32'(q_s2) * 32'(SEC_PER_MIN);
		r1    = diff1[6:0];
		c1    = r1 >= 7'(SEC_PER_MIN);
		p2    = 49'(t1_s3) * 49'(RCP_60_W27);
		diff2 = t1_s4 - 27'(q_s4) * 27'(MIN_PER_HOUR);
		r2    = diff2[6:0];
		c2    = r2 >= 7'(MIN_PER_HOUR);
		p3    = 38'(t2_s5) * 38'(RCP_24_W21);
		diff3 = t2_s6 - 21'(q_s6) * 21'(HOUR_PER_DAY);
		r3    = diff3[5:0];
		c3    = r3 >= 6'(HOUR_PER_DAY);
		t3    = q_s6 + 16'(c3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ok_s1 <= ntp_seconds > NTP_UNIX_DIFF;
			t_s1  <= ntp_seconds - NTP_UNIX_DIFF + {{15{utc_offset[16]}}, utc_offset};
		end
		if (rdy_s2) begin
			ok_s2 <= ok_s1;
			t_s2  <= t_s1;
			q_s2  <= p1[58:32];
		end
		if (rdy_s3) begin
			ok_s3  <= ok_s2;
			sec_s3 <= c1 ? 6'(r1 - 7'(SEC_PER_MIN)) : r1[5:0];
			t1_s3  <= q_s2 + 27'(c1);
		end
		if (rdy_s4) begin
			ok_s4  <= ok_s3;
			sec_s4 <= sec_s3;
			t1_s4  <= t1_s3;
			q_s4   <= p2[47:27];
		end
		if (rdy_s5) begin
			ok_s5  <= ok_s4;
			sec_s5 <= sec_s4;
			min_s5 <= c2 ? 6'(r2 - 7'(MIN_PER_HOUR)) : r2[5:0];
			t2_s5  <= q_s4 + 21'(c2);
		end
		if (rdy_s6) begin
			ok_s6  <= ok_s5;
			sec_s6 <= sec_s5;
			min_s6 <= min_s5;
			t2_s6  <= t2_s5;
			q_s6   <= p3[36:21];
		end
		if (rdy_s7) begin
			ok_s7  <= ok_s6;
			sec_s7 <= sec_s6;
			min_s7 <= min_s6;
			hr_s7  <= c3 ? 5'(r3 - 6'(HOUR_PER_DAY)) : r3[4:0];
			z_s7   <= 20'(t3) + EPOCH_DAYS;
		end
	end

	assign out_valid           = v_s7;
	assign out_data.hms.ok     = ok_s7;
	assign out_data.hms.hour   = hr_s7;
	assign out_data.hms.minute = min_s7;
	assign out_data.hms.second = sec_s7;
	assign out_data.z          = z_s7;

endmodule

// ----- rtl/ntpsc_date.sv -----
// ----------------------------------------------------------------------------
// ntpsc_date
// Day count to year, month and day over 400-year eras starting in March.
// ----------------------------------------------------------------------------
module ntpsc_date (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ntpsc_pkg::tod_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output ntpsc_pkg::civ_t out_data
);
	import ntpsc_pkg::*;

	function automatic logic [8:0] month_start_f(input logic [3:0] mp);
		logic [8:0] d;
		case (mp)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8;
	hms_t hms_s1, hms_s2, hms_s3, hms_s4, hms_s5, hms_s6, hms_s7;

	logic [2:0]  era_s1, era_s2, era_s3, era_s4, era_s5;
	logic [17:0] doe_s1, doe_s2, doe_s3, doe_s4, doe_s5;
	logic [6:0]  q0_s2;
	logic [2:0]  cent_s2;
	logic        last_s2;
	logic [17:0] n_s3, n_s4;
	logic [8:0]  yoe0_s4;
	logic [8:0]  yoe_s5;
	logic [8:0]  doy_s6, doy_s7;
	logic [11:0] yr_s6, yr_s7;
	logic [3:0]  mp_s7;
	civ_t        res_s8;

	logic [2:0]  era_n;
	logic [19:0] doe_w;
	logic [25:0] pq;
	logic [2:0]  cent_n;
	logic [17:0] diff_q;
	logic [11:0] rq;
	logic [6:0]  q1460;
	logic [27:0] py;
	logic [17:0] diff_y;
	logic [9:0]  ry;
	logic [1:0]  c100;
	logic [17:0] yday;
	logic [10:0] x5;
	logic [3:0]  mp_n;

	assign rdy_s8   = !v_s8 || out_ready;
	assign rdy_s7   = !v_s7 || rdy_s8;
	assign rdy_s6   = !v_s6 || rdy_s7;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		era_n = '0;
		for (int k = 1; k <= 5; k++) begin
			era_n = era_n + 3'(in_data.z >= 20'(k * DAYS_PER_ERA));
		end
		doe_w = in_data.z - 20'(era_n) * 20'(DAYS_PER_ERA);

		pq     = 26'(doe_s1) * 26'(RCP_1460_W18);
		cent_n = '0;
		for (int k = 1; k <= 4; k++) begin
			cent_n = cent_n + 3'(doe_s1 >= 18'(k * DAYS_PER_CENT));
		end

		diff_q = doe_s2 - 18'(q0_s2) * 18'(DAYS_PER_4Y);
		rq     = diff_q[11:0];
		q1460  = q0_s2 + 7'(rq >= 12'(DAYS_PER_4Y));

		py     = 28'(n_s3) * 28'(RCP_365_W18);

		diff_y = n_s4 - 18'(yoe0_s4) * 18'(DAYS_PER_YEAR);
		ry     = diff_y[9:0];

		c100 = 2'(yoe_s5 >= 9'd100) + 2'(yoe_s5 >= 9'd200) + 2'(yoe_s5 >= 9'd300);
		yday = 18'(yoe_s5) * 18'(DAYS_PER_YEAR) + 18'(yoe_s5 >> 2) - 18'(c100);

		x5   = 11'(doy_s6) * 11'd5 + 11'd2;
		mp_n = '0;
		for (int k = 1; k <= 11; k++) begin
			mp_n = mp_n + 4'(x5 >= 11'(k * MP_DAYS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
			if (rdy_s8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			hms_s1 <= in_data.hms;
			era_s1 <= era_n;
			doe_s1 <= doe_w[17:0];
		end
		if (rdy_s2) begin
			hms_s2  <= hms_s1;
			era_s2  <= era_s1;
			doe_s2  <= doe_s1;
			q0_s2   <= pq[24:18];
			cent_s2 <= cent_n;
			last_s2 <= doe_s1 >= 18'(ERA_LAST_DAY);
		end
		if (rdy_s3) begin
			hms_s3 <= hms_s2;
			era_s3 <= era_s2;
			doe_s3 <= doe_s2;
			n_s3   <= doe_s2 - 18'(q1460) + 18'(cent_s2) - 18'(last_s2);
		end
		if (rdy_s4) begin
			hms_s4  <= hms_s3;
			era_s4  <= era_s3;
			doe_s4  <= doe_s3;
			n_s4    <= n_s3;
			yoe0_s4 <= py[26:18];
		end
		if (rdy_s5) begin
			hms_s5 <= hms_s4;
			era_s5 <= era_s4;
			doe_s5 <= doe_s4;
			yoe_s5 <= yoe0_s4 + 9'(ry >= 10'(DAYS_PER_YEAR));
		end
		if (rdy_s6) begin
			hms_s6 <= hms_s5;
			doy_s6 <= 9'(doe_s5 - yday);
			yr_s6  <= 12'(yoe_s5) + 12'(era_s5) * 12'(YEARS_PER_ERA);
		end
		if (rdy_s7) begin
			hms_s7 <= hms_s6;
			doy_s7 <= doy_s6;
			yr_s7  <= yr_s6;
			mp_s7  <= mp_n;
		end
		if (rdy_s8) begin
			res_s8.ok     <= hms_s7.ok;
			res_s8.hour   <= hms_s7.hour;
			res_s8.minute <= hms_s7.minute;
			res_s8.second <= hms_s7.second;
			res_s8.day    <= 5'(doy_s7 - month_start_f(mp_s7) + 9'd1);
			res_s8.month  <= (mp_s7 < 4'(MP_JAN)) ? mp_s7 + 4'(MP_MARCH_OFS)
			                                      : mp_s7 - 4'(MP_JAN_OFS);
			res_s8.year   <= yr_s7 + 12'(mp_s7 >= 4'(MP_JAN));
		end
	end

	assign out_valid = v_s8;
	assign out_data  = res_s8;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the NTP seconds to civil time converter.
// ----------------------------------------------------------------------------
// Timestamps stream in through the valid/ready input while both sides idle at
// random outside phase 2. A predictor turns each accepted timestamp into date
// and time under the current local offset. The monitor checks every result
// field against the oldest prediction. The offset is rewritten over the APB
// port between phases, at its extremes, past its range and at random.
// ----------------------------------------------------------------------------
module tb;
	import ntpsc_pkg::*;

	localparam logic [2:0]  ADDR_UTC_OFFSET = {REG_UTC_OFFSET, 2'b00};
	localparam logic [2:0]  ADDR_UNMAPPED   = 3'd4;
	localparam int unsigned N_PHASES        = 8;
	localparam int unsigned ITEMS_PER_PHASE = 222;
	localparam int unsigned DRAIN_CYCLES    = 24;
	localparam int unsigned STALL_LIMIT     = 4000;
	localparam int unsigned PRINT_LIMIT     = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        ntp_valid = 1'b0;
	logic        ntp_ready;
	logic [31:0] ntp_seconds = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic        time_valid;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	logic [31:0] stamp_q[$];
	civ_t        civil_due[$];
	logic [16:0] offset_now = '0;
	logic        idle_en = 1'b1;
	int unsigned n_err = 0;
	int unsigned n_stamps = 0;
	int unsigned n_pre_epoch = 0;
	int unsigned n_results = 0;
	int unsigned n_offsets = 0;
	int unsigned stall_cnt = 0;

	ntp_seconds_to_civil_time_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.ntp_valid    (ntp_valid),
		.ntp_ready    (ntp_ready),
		.ntp_seconds  (ntp_seconds),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.time_valid   (time_valid),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.hour         (hour),
		.minute       (minute),
		.second       (second)
	);

	always #6 clk = ~clk;

	function automatic civ_t civil_of(input logic [31:0] ntp, input logic [16:0] ofs);
		civ_t        r;
		logic [31:0] t, z, era, doe, yoe, yr, doy, mp, mday, mon;
		r = '0;
		if (ntp > NTP_UNIX_DIFF) begin
			t = ntp - NTP_UNIX_DIFF + {{15{ofs[16]}}, ofs};
			r.second = 6'(t % 32'd60);
			t = t / 32'd60;
			r.minute = 6'(t % 32'd60);
			t = t / 32'd60;
			r.hour = 5'(t % 32'd24);
			t = t / 32'd24;
			z = t + 32'd719468;
			era = z / 32'd146097;
			doe = z - era * 32'd146097;
			yoe = (doe - doe / 32'd1460 + doe / 32'd36524 - doe / 32'd146096) / 32'd365;
			yr = yoe + era * 32'd400;
			doy = doe - (32'd365 * yoe + yoe / 32'd4 - yoe / 32'd100);
			mp = (32'd5 * doy + 32'd2) / 32'd153;
			mday = doy - (32'd153 * mp + 32'd2) / 32'd5 + 32'd1;
			mon = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
			if (mon <= 32'd2)
				yr = yr + 32'd1;
			r.ok = 1'b1;
			r.year = yr[11:0];
			r.month = mon[3:0];
			r.day = mday[4:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] pick_stamp();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 60)
			return NTP_UNIX_DIFF + 32'd1 + $urandom_range(32'hFFFF_FFFF - NTP_UNIX_DIFF - 32'd1);
		if (k < 72)
			return NTP_UNIX_DIFF + 32'd86400 * $urandom_range(24142, 1) - $urandom_range(1);
		if (k < 82)
			return NTP_UNIX_DIFF - 32'd200 + $urandom_range(120000);
		if (k < 90)
			return 32'hFFFF_FFFF - $urandom_range(200000);
		return $urandom;
	endfunction

	task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
		if (n_err < PRINT_LIMIT)
			$display("%0t mismatch on %s: want %0d got %0d", $realtime, what, want, got);
		n_err++;
	endtask

	task automatic check_result(input civ_t want);
		if (time_valid !== want.ok)
			report("time_valid", want.ok, time_valid);
		if (year !== want.year)
			report("year", want.year, year);
		if (month !== want.month)
			report("month", want.month, month);
		if (day_of_month !== want.day)
			report("day_of_month", want.day, day_of_month);
		if (hour !== want.hour)
			report("hour", want.hour, hour);
		if (minute !== want.minute)
			report("minute", want.minute, minute);
		if (second !== want.second)
			report("second", want.second, second);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_UTC_OFFSET) begin
			offset_now = data[16:0];
			n_offsets++;
		end
	endtask

	task automatic check_offset_readback();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_UTC_OFFSET;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[16:0] !== offset_now)
			report("utc_offset readback", offset_now, prdata[16:0]);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		do @(negedge clk); while (stamp_q.size() != 0 || ntp_valid || civil_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// driver: hold each item until accepted, predict its result on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ntp_valid <= 1'b0;
			ntp_seconds <= '0;
		end else if (!ntp_valid || ntp_ready) begin
			if (ntp_valid) begin
				civil_due.push_back(civil_of(ntp_seconds, offset_now));
				n_stamps++;
				if (ntp_seconds <= NTP_UNIX_DIFF)
					n_pre_epoch++;
			end
			if (stamp_q.size() != 0 && !(idle_en && $urandom_range(99) < 27)) begin
				ntp_valid <= 1'b1;
				ntp_seconds <= stamp_q.pop_front();
			end else begin
				ntp_valid <= 1'b0;
			end
		end
	end

	// monitor: check each result item against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				n_results++;
				if (civil_due.size() == 0)
					report("unexpected result, time_valid", 0, time_valid);
				else
					check_result(civil_due.pop_front());
			end
			res_ready <= idle_en ? ($urandom_range(99) >= 27) : 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (ntp_valid && ntp_ready) || (res_valid && res_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt == STALL_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		logic [31:0] corner[$];
		logic [31:0] wrap[$];
		logic [31:0] wdata;
		corner = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, NTP_UNIX_DIFF - 32'd1, NTP_UNIX_DIFF,
			NTP_UNIX_DIFF + 32'd1, NTP_UNIX_DIFF + 32'd59, NTP_UNIX_DIFF + 32'd60,
			NTP_UNIX_DIFF + 32'd3599, NTP_UNIX_DIFF + 32'd86399, NTP_UNIX_DIFF + 32'd86400,
			32'd3160771200, 32'd3160857600, 32'd3918153600, 32'd3944678399,
			32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000};
		wrap = '{NTP_UNIX_DIFF + 32'd1, NTP_UNIX_DIFF + 32'd50399, NTP_UNIX_DIFF + 32'd50400,
			NTP_UNIX_DIFF + 32'd50401, 32'hFFFF_FFFF};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		check_offset_readback();
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
			0: wdata = 32'd0;
			1: wdata = -32'sd50400;
			2: wdata = 32'd50400;
			3: wdata = 32'h0001_0000;
			4: wdata = 32'h0000_FFFF;
			5: wdata = $urandom;
			default: wdata = 32'($urandom_range(100800)) - 32'd50400;
			endcase
			if (p == 5) begin
				apb_write(ADDR_UNMAPPED, $urandom);
				check_offset_readback();
			end
			apb_write(ADDR_UTC_OFFSET, wdata);
			check_offset_readback();
			idle_en = (p != 2);
			if (p == 0)
				foreach (corner[i]) stamp_q.push_back(corner[i]);
			if (p == 1)
				foreach (wrap[i]) stamp_q.push_back(wrap[i]);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				stamp_q.push_back(pick_stamp());
			drain();
		end
		$display("ran %0d timestamps (%0d at or before 1970) under %0d offset writes",
			n_stamps, n_pre_epoch, n_offsets);
		$display("checked %0d result items, %0d mismatches", n_results, n_err);
		if (n_err == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
